>>> hdl/rk4pp_pkg.sv
// Package for the RK4 predator-prey step block: widths, fixed-point constants,
// operand map of the shared arithmetic unit and the microprogram decode.
// No dependencies.
package rk4pp_pkg;

  localparam int POP_FRAC_BITS = 24;
  localparam int POP_W         = 48;
  localparam int DATA_W        = 52;
  localparam int HALF_W        = POP_W / 2;
  localparam int PROD_W        = 2 * POP_W;
  localparam int ADDR_W        = 6;
  localparam int SH_W          = 6;
  localparam int STEP_W        = 32;
  localparam int NPOP          = 5;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SH_W-1:0]   shamt_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_ADDW, OP_ADD2W, OP_SAT, OP_DIV6
  } op_e;

  typedef struct packed {
    op_e    op;
    addr_t  dst;
    addr_t  src_a;
    addr_t  src_b;
    shamt_t shift;
  } instr_t;

  // Register-file slots
  localparam addr_t A_V  = 6'd0;   // stage vector V0..V4
  localparam addr_t A_D  = 6'd5;   // derivative D0..D4
  localparam addr_t A_S  = 6'd10;  // weighted sum S0..S4
  localparam addr_t V0 = 6'd0, V1 = 6'd1, V2 = 6'd2, V3 = 6'd3, V4 = 6'd4;
  localparam addr_t D0 = 6'd5, D1 = 6'd6, D2 = 6'd7, D3 = 6'd8, D4 = 6'd9;
  localparam addr_t T0 = 6'd15, T1 = 6'd16, T2 = 6'd17, T3 = 6'd18;
  localparam addr_t T4 = 6'd19, T5 = 6'd20, T6 = 6'd21;
  // Sources above the register file: populations, constants, registers
  localparam addr_t A_P    = 6'd32;
  localparam addr_t A_P0 = 6'd32, A_P1 = 6'd33, A_P2 = 6'd34, A_P3 = 6'd35, A_P4 = 6'd36;
  localparam addr_t A_ALPHA = 6'd37;
  localparam addr_t A_BETA  = 6'd38;
  localparam addr_t A_B1    = 6'd39;
  localparam addr_t A_B23   = 6'd40;
  localparam addr_t A_DIE   = 6'd41;
  localparam addr_t A_ONE   = 6'd42;
  localparam addr_t A_H     = 6'd43;
  localparam addr_t A_R1    = 6'd44;
  localparam addr_t A_R2    = 6'd45;
  localparam addr_t A_ZERO  = 6'd46;

  localparam shamt_t SH_POP   = SH_W'(POP_FRAC_BITS);
  localparam shamt_t SH_RATE  = 6'd30;
  localparam shamt_t SH_RECIP = 6'd32;
  localparam shamt_t SH_HALF  = 6'd25;
  localparam shamt_t SH_FULL  = 6'd24;
  localparam shamt_t SH_DIV6  = 6'd50;
  localparam shamt_t SH_NONE  = 6'd0;

  // Rate constants, unsigned Q2.30
  localparam logic [31:0] C_B1    = 32'd858993459;
  localparam logic [31:0] C_B23   = 32'd1717986918;
  localparam logic [31:0] C_DIE   = 32'd966367642;
  localparam logic [31:0] C_ALPHA = 32'd53579436;
  localparam logic [31:0] C_BETA  = 32'd53687091;
  // floor(2^50 / 6)
  localparam logic [POP_W-1:0] DIV6_RECIP = 48'd187649984473770;

  localparam logic [POP_W-1:0] MAXMAG    = {1'b0, {(POP_W-1){1'b1}}};
  localparam logic [POP_W-1:0] POP_RESET = POP_W'(10) << POP_FRAC_BITS;

  localparam logic [4:0] DERIV_LAST = 5'd31;

  function automatic instr_t mk(op_e op, addr_t d, addr_t a, addr_t b, shamt_t s);
    instr_t r;
    r.op = op; r.dst = d; r.src_a = a; r.src_b = b; r.shift = s;
    return r;
  endfunction

  // One derivative evaluation of vector V into D
  function automatic instr_t deriv_instr(logic [4:0] idx);
    instr_t r;
    case (idx)
      5'd0:  r = mk(OP_MUL, T0, V4, A_ALPHA, SH_RATE);
      5'd1:  r = mk(OP_MUL, T1, V3, A_ALPHA, SH_RATE);
      5'd2:  r = mk(OP_ADD, T0, T0, T1, SH_NONE);
      5'd3:  r = mk(OP_MUL, T1, V2, A_BETA, SH_RATE);
      5'd4:  r = mk(OP_MUL, T2, V0, A_ALPHA, SH_RATE);
      5'd5:  r = mk(OP_ADD, T1, T1, T2, SH_NONE);
      5'd6:  r = mk(OP_MUL, T3, V1, A_BETA, SH_RATE);
      5'd7:  r = mk(OP_ADD, T2, T3, T2, SH_NONE);
      5'd8:  r = mk(OP_MUL, T3, V0, T0, SH_POP);
      5'd9:  r = mk(OP_MUL, T3, T3, A_B1, SH_RATE);
      5'd10: r = mk(OP_MUL, T4, V0, A_DIE, SH_RATE);
      5'd11: r = mk(OP_SUB, D0, T3, T4, SH_NONE);
      5'd12: r = mk(OP_MUL, T3, V4, A_BETA, SH_RATE);
      5'd13: r = mk(OP_MUL, T3, V1, T3, SH_POP);
      5'd14: r = mk(OP_MUL, T3, T3, A_B23, SH_RATE);
      5'd15: r = mk(OP_MUL, T4, V1, A_DIE, SH_RATE);
      5'd16: r = mk(OP_SUB, D1, T3, T4, SH_NONE);
      5'd17: r = mk(OP_MUL, T3, V3, A_BETA, SH_RATE);
      5'd18: r = mk(OP_MUL, T3, V2, T3, SH_POP);
      5'd19: r = mk(OP_MUL, T3, T3, A_B23, SH_RATE);
      5'd20: r = mk(OP_MUL, T4, V2, A_DIE, SH_RATE);
      5'd21: r = mk(OP_SUB, D2, T3, T4, SH_NONE);
      5'd22: r = mk(OP_MUL, T3, V3, A_R1, SH_RECIP);
      5'd23: r = mk(OP_SUB, T3, A_ONE, T3, SH_NONE);
      5'd24: r = mk(OP_MUL, T3, V3, T3, SH_POP);
      5'd25: r = mk(OP_MUL, T4, V3, T1, SH_POP);
      5'd26: r = mk(OP_SUB, D3, T3, T4, SH_NONE);
      5'd27: r = mk(OP_MUL, T3, V4, A_R2, SH_RECIP);
      5'd28: r = mk(OP_SUB, T3, A_ONE, T3, SH_NONE);
      5'd29: r = mk(OP_MUL, T3, V4, T3, SH_POP);
      5'd30: r = mk(OP_MUL, T4, V4, T2, SH_POP);
      default: r = mk(OP_SUB, D4, T3, T4, SH_NONE);
    endcase
    return r;
  endfunction

  // Accumulate k and form the next stage vector; stage 0..2
  function automatic instr_t upd_instr(logic [1:0] stage, logic [2:0] el, logic [1:0] sub);
    instr_t r;
    addr_t  e;
    shamt_t sh;
    e  = addr_t'(el);
    sh = (stage == 2'd2) ? SH_FULL : SH_HALF;
    case (sub)
      2'd0: begin
        if (stage == 2'd0) r = mk(OP_ADDW, A_S + e, A_D + e, A_ZERO, SH_NONE);
        else               r = mk(OP_ADD2W, A_S + e, A_S + e, A_D + e, SH_NONE);
      end
      2'd1: r = mk(OP_MUL, T5, A_D + e, A_H, sh);
      default: r = mk(OP_ADD, A_V + e, A_P + e, T5, SH_NONE);
    endcase
    return r;
  endfunction

  // Final weighted sum, scale by h/6 and population update
  function automatic instr_t final_instr(logic [2:0] el, logic [2:0] sub);
    instr_t r;
    addr_t  e;
    e = addr_t'(el);
    case (sub)
      3'd0: r = mk(OP_ADDW, A_S + e, A_S + e, A_D + e, SH_NONE);
      3'd1: r = mk(OP_SAT, A_S + e, A_S + e, A_ZERO, SH_NONE);
      3'd2: r = mk(OP_MUL, T5, A_S + e, A_H, SH_FULL);
      3'd3: r = mk(OP_DIV6, T6, T5, A_ZERO, SH_DIV6);
      default: r = mk(OP_ADD, A_P + e, A_P + e, T6, SH_NONE);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/rk4_predator_prey_step_top.sv
// Top level of the RK4 predator-prey step block: sequencer, register file,
// shared multiply / add unit, configuration registers. Uses rk4pp_pkg.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / year_code_i): one transaction is
//   one time tick. in_stall_o is high from acceptance until the result has
//   been moved into the output register, so one tick is worked on at a time.
//   Output channel (out_valid_o / out_stall_i / *_count_o, step_index_o,
//   crashed_o): one transaction per tick, held while out_stall_i is high.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
//   cfg_data_i): always ready; write only while no tick is in flight.
// Operation
//   Each tick runs a microprogram on one shared 24x24 multiplier and one
//   adder: 113 multiply or divide-by-six operations and 90 add / subtract /
//   saturate operations, then the crash check and the result load. Once the
//   crash flag is set, an accepted tick skips the microprogram and goes
//   straight to the result load.
//   A result waiting under out_stall_i does not block the next acceptance;
//   the next result waits in the final state until the output register frees.
// Reset
//   rst_ni clears control state, loads the register reset values, sets all
//   five populations to 10.0 and clears the step counter and crash flag.
module rk4_predator_prey_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  year_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] predator_one_count_o,
  output logic [47:0] predator_two_count_o,
  output logic [47:0] predator_three_count_o,
  output logic [47:0] prey_one_count_o,
  output logic [47:0] prey_two_count_o,
  output logic [31:0] step_index_o,
  output logic        crashed_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import rk4pp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_SHIFT, ST_FIX, ST_CHECK, ST_DONE
  } state_e;

  typedef enum logic [1:0] {SEG_COPY, SEG_DERIV, SEG_UPD, SEG_FINAL} seg_e;

  typedef enum logic [2:0] {
    CFG_STEP, CFG_R1_GOOD, CFG_R2_GOOD, CFG_R1_HARSH, CFG_R2_HARSH,
    CFG_PRED_FLOOR, CFG_PREY_FLOOR
  } cfg_e;

  localparam logic signed [DATA_W+1:0] SAT_HI = (DATA_W+2)'(MAXMAG);
  localparam logic signed [DATA_W+1:0] SAT_LO = -SAT_HI - 1;

  // Configuration registers
  logic [23:0]      step_q;
  logic [31:0]      r1_good_q, r2_good_q, r1_harsh_q, r2_harsh_q;
  logic [POP_W-1:0] pred_floor_q, prey_floor_q;

  // Architectural state
  logic [NPOP-1:0][POP_W-1:0] pop_q;
  logic [STEP_W-1:0]          step_cnt_q;
  logic                       crash_q;
  logic [1:0]                 year_q;

  // Sequencer
  state_e     state_q;
  seg_e       seg_q, seg_d;
  logic [1:0] stage_q, stage_d;
  logic [2:0] elem_q, elem_d;
  logic [4:0] sub_q, sub_d;
  logic       seq_end;
  instr_t     instr, instr_q;

  // Operands and shared unit
  logic signed [DATA_W-1:0] rf [32];
  logic signed [DATA_W-1:0] rfa_q, rfb_q, cona_q, conb_q;
  logic                     sela_q, selb_q;
  logic signed [DATA_W-1:0] opa, opb;
  logic [POP_W-1:0]         amag_q, bmag_q, mag_q;
  logic                     neg_q;
  logic [1:0]               pp_cnt_q;
  logic [PROD_W:0]          acc_q;

  // Output register
  logic                       out_valid_q;
  logic [NPOP-1:0][POP_W-1:0] out_pop_q;
  logic [STEP_W-1:0]          out_step_q;
  logic                       out_crash_q;

  function automatic logic signed [DATA_W-1:0] sx(logic [POP_W-1:0] v);
    return {{(DATA_W-POP_W){v[POP_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat48(logic signed [DATA_W+1:0] x);
    if (x > SAT_HI) return DATA_W'(SAT_HI);
    if (x < SAT_LO) return DATA_W'(SAT_LO);
    return DATA_W'(x);
  endfunction

  function automatic logic [POP_W-1:0] mag_of(logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] n;
    n = -v;
    return v[DATA_W-1] ? n[POP_W-1:0] : v[POP_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] src_const(addr_t s);
    logic signed [DATA_W-1:0] r;
    case (s)
      A_P0:    r = sx(pop_q[0]);
      A_P1:    r = sx(pop_q[1]);
      A_P2:    r = sx(pop_q[2]);
      A_P3:    r = sx(pop_q[3]);
      A_P4:    r = sx(pop_q[4]);
      A_ALPHA: r = DATA_W'(C_ALPHA);
      A_BETA:  r = DATA_W'(C_BETA);
      A_B1:    r = DATA_W'(C_B1);
      A_B23:   r = DATA_W'(C_B23);
      A_DIE:   r = DATA_W'(C_DIE);
      A_ONE:   r = DATA_W'(1) << POP_FRAC_BITS;
      A_H:     r = DATA_W'(step_q);
      A_R1:    r = DATA_W'(year_q[0] ? r1_harsh_q : r1_good_q);
      A_R2:    r = DATA_W'(year_q[1] ? r2_harsh_q : r2_good_q);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Microprogram decode from the sequencer counters
  always_comb begin
    case (seg_q)
      SEG_COPY:  instr = mk(OP_ADDW, A_V + addr_t'(elem_q), A_P + addr_t'(elem_q),
                            A_ZERO, SH_NONE);
      SEG_DERIV: instr = deriv_instr(sub_q);
      SEG_UPD:   instr = upd_instr(stage_q, elem_q, sub_q[1:0]);
      default:   instr = final_instr(elem_q, sub_q[2:0]);
    endcase
  end

  // Advance the microprogram after each completed operation
  always_comb begin
    seg_d   = seg_q;
    stage_d = stage_q;
    elem_d  = elem_q;
    sub_d   = sub_q;
    seq_end = 1'b0;
    case (seg_q)
      SEG_COPY: begin
        if (elem_q == 3'(NPOP-1)) begin
          elem_d = '0;
          seg_d  = SEG_DERIV;
        end else begin
          elem_d = elem_q + 3'd1;
        end
      end
      SEG_DERIV: begin
        if (sub_q == DERIV_LAST) begin
          sub_d = '0;
          seg_d = (stage_q == 2'd3) ? SEG_FINAL : SEG_UPD;
        end else begin
          sub_d = sub_q + 5'd1;
        end
      end
      SEG_UPD: begin
        if (sub_q == 5'd2) begin
          sub_d = '0;
          if (elem_q == 3'(NPOP-1)) begin
            elem_d  = '0;
            stage_d = stage_q + 2'd1;
            seg_d   = SEG_DERIV;
          end else begin
            elem_d = elem_q + 3'd1;
          end
        end else begin
          sub_d = sub_q + 5'd1;
        end
      end
      default: begin
        if (sub_q == 5'd4) begin
          sub_d = '0;
          if (elem_q == 3'(NPOP-1)) seq_end = 1'b1;
          else elem_d = elem_q + 3'd1;
        end else begin
          sub_d = sub_q + 5'd1;
        end
      end
    endcase
  end

  assign opa = sela_q ? cona_q : rfa_q;
  assign opb = selb_q ? conb_q : rfb_q;

  // Combinational add / subtract / saturate
  logic signed [DATA_W+1:0] ea, eb;
  logic signed [DATA_W-1:0] alu_res;
  assign ea = (DATA_W+2)'(opa);
  assign eb = (DATA_W+2)'(opb);
  always_comb begin
    case (instr_q.op)
      OP_ADD:   alu_res = sat48(ea + eb);
      OP_SUB:   alu_res = sat48(ea - eb);
      OP_ADDW:  alu_res = DATA_W'(ea + eb);
      OP_ADD2W: alu_res = DATA_W'(ea + (eb <<< 1));
      OP_SAT:   alu_res = sat48(ea);
      default:  alu_res = '0;
    endcase
  end

  // One partial product per cycle, low half first
  logic [HALF_W-1:0] pa, pb;
  logic [POP_W-1:0]  pprod;
  logic [PROD_W:0]   pp_sh;
  assign pa    = pp_cnt_q[1] ? amag_q[POP_W-1:HALF_W] : amag_q[HALF_W-1:0];
  assign pb    = pp_cnt_q[0] ? bmag_q[POP_W-1:HALF_W] : bmag_q[HALF_W-1:0];
  assign pprod = pa * pb;
  always_comb begin
    case (pp_cnt_q)
      2'd0:    pp_sh = (PROD_W+1)'(pprod);
      2'd3:    pp_sh = (PROD_W+1)'(pprod) << POP_W;
      default: pp_sh = (PROD_W+1)'(pprod) << HALF_W;
    endcase
  end

  // Round, shift and clamp the full product
  logic [PROD_W:0] rnd, tot, shd;
  assign rnd = (instr_q.op == OP_MUL) ? ((PROD_W+1)'(1) << (instr_q.shift - SH_W'(1)))
                                      : '0;
  assign tot = acc_q + rnd;
  assign shd = tot >> instr_q.shift;

  // Final result of a multiply or divide-by-six
  logic [POP_W+1:0]         six_q0, rem;
  logic [POP_W-1:0]         quo;
  logic signed [DATA_W-1:0] mres, fix_res;
  assign six_q0 = {mag_q, 2'b00} + {1'b0, mag_q, 1'b0};
  assign rem    = {2'b00, amag_q} - six_q0;
  assign quo    = (rem >= (POP_W+2)'(6)) ? mag_q + POP_W'(1) : mag_q;
  assign mres   = (instr_q.op == OP_DIV6) ? DATA_W'(quo) : DATA_W'(mag_q);
  assign fix_res = neg_q ? -mres : mres;

  // Register-file / population write
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;
  assign wr_en   = ((state_q == ST_EXEC) && (instr_q.op != OP_MUL) && (instr_q.op != OP_DIV6))
                || (state_q == ST_FIX);
  assign wr_data = (state_q == ST_FIX) ? fix_res : alu_res;

  always_ff @(posedge clk_i) begin
    if (wr_en && !instr_q.dst[ADDR_W-1]) rf[instr_q.dst[4:0]] <= wr_data;
    rfa_q <= rf[instr.src_a[4:0]];
    rfb_q <= rf[instr.src_b[4:0]];
  end

  // Crash check on the new populations
  logic [NPOP-1:0] below;
  always_comb begin
    for (int i = 0; i < NPOP; i++) begin
      below[i] = $signed(pop_q[i]) < $signed({1'b0, (i < 3) ? pred_floor_q : prey_floor_q});
    end
  end

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_q        <= SEG_COPY;
      stage_q      <= '0;
      elem_q       <= '0;
      sub_q        <= '0;
      step_q       <= 24'd33554;
      r1_good_q    <= 32'd429497;
      r2_good_q    <= 32'd429497;
      r1_harsh_q   <= 32'd42949673;
      r2_harsh_q   <= 32'd42949673;
      pred_floor_q <= POP_W'(1) << POP_FRAC_BITS;
      prey_floor_q <= POP_W'(1) << POP_FRAC_BITS;
      pop_q        <= {NPOP{POP_RESET}};
      step_cnt_q   <= '0;
      crash_q      <= 1'b0;
      year_q       <= '0;
      instr_q      <= '0;
      cona_q       <= '0;
      conb_q       <= '0;
      sela_q       <= 1'b0;
      selb_q       <= 1'b0;
      amag_q       <= '0;
      bmag_q       <= '0;
      mag_q        <= '0;
      neg_q        <= 1'b0;
      pp_cnt_q     <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      out_pop_q    <= '0;
      out_step_q   <= '0;
      out_crash_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_STEP:       step_q       <= cfg_data_i[23:0];
          CFG_R1_GOOD:    r1_good_q    <= cfg_data_i[31:0];
          CFG_R2_GOOD:    r2_good_q    <= cfg_data_i[31:0];
          CFG_R1_HARSH:   r1_harsh_q   <= cfg_data_i[31:0];
          CFG_R2_HARSH:   r2_harsh_q   <= cfg_data_i[31:0];
          CFG_PRED_FLOOR: pred_floor_q <= cfg_data_i;
          CFG_PREY_FLOOR: prey_floor_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drain the output register; the final state reloads it instead
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;

      if (wr_en && instr_q.dst[ADDR_W-1]) begin
        pop_q[instr_q.dst[2:0]] <= wr_data[POP_W-1:0];
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            year_q  <= year_code_i;
            seg_q   <= SEG_COPY;
            stage_q <= '0;
            elem_q  <= '0;
            sub_q   <= '0;
            state_q <= crash_q ? ST_DONE : ST_FETCH;
          end
        end
        ST_FETCH: begin
          instr_q <= instr;
          cona_q  <= src_const(instr.src_a);
          conb_q  <= src_const(instr.src_b);
          sela_q  <= instr.src_a[ADDR_W-1];
          selb_q  <= instr.src_b[ADDR_W-1];
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          acc_q    <= '0;
          pp_cnt_q <= '0;
          if (instr_q.op == OP_DIV6) begin
            amag_q  <= mag_of(opa) + POP_W'(3);
            bmag_q  <= DIV6_RECIP;
            neg_q   <= opa[DATA_W-1];
            state_q <= ST_MUL;
          end else if (instr_q.op == OP_MUL) begin
            amag_q  <= mag_of(opa);
            bmag_q  <= mag_of(opb);
            neg_q   <= opa[DATA_W-1] ^ opb[DATA_W-1];
            state_q <= ST_MUL;
          end else begin
            seg_q   <= seg_d;
            stage_q <= stage_d;
            elem_q  <= elem_d;
            sub_q   <= sub_d;
            state_q <= seq_end ? ST_CHECK : ST_FETCH;
          end
        end
        ST_MUL: begin
          acc_q    <= acc_q + pp_sh;
          pp_cnt_q <= pp_cnt_q + 2'd1;
          if (pp_cnt_q == 2'd3) state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          mag_q   <= (shd > (PROD_W+1)'(MAXMAG)) ? MAXMAG : shd[POP_W-1:0];
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          seg_q   <= seg_d;
          stage_q <= stage_d;
          elem_q  <= elem_d;
          sub_q   <= sub_d;
          state_q <= seq_end ? ST_CHECK : ST_FETCH;
        end
        ST_CHECK: begin
          step_cnt_q <= step_cnt_q + STEP_W'(1);
          if (|below) crash_q <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // Load the result once the output register is free or drains now
          if (!out_valid_q || !out_stall_i) begin
            for (int i = 0; i < NPOP; i++) begin
              out_pop_q[i] <= pop_q[i][POP_W-1] ? '0 : pop_q[i];
            end
            out_step_q  <= step_cnt_q;
            out_crash_q <= crash_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o             = (state_q != ST_IDLE);
  assign cfg_ready_o            = 1'b1;
  assign out_valid_o            = out_valid_q;
  assign predator_one_count_o   = out_pop_q[0];
  assign predator_two_count_o   = out_pop_q[1];
  assign predator_three_count_o = out_pop_q[2];
  assign prey_one_count_o       = out_pop_q[3];
  assign prey_two_count_o       = out_pop_q[4];
  assign step_index_o           = out_step_q;
  assign crashed_o              = out_crash_q;

  // Crash flag is sticky
  a_crash_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crash_q |=> crash_q) else $error("crash flag cleared");

  // Frozen state: populations never change once crashed
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crash_q |=> $stable(pop_q)) else $error("population changed after crash");

  // Step counter moves only in the check state
  a_step_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CHECK) |=> $stable(step_cnt_q)) else $error("step count moved");

  // A finished result is loaded as soon as the output register frees
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !(out_valid_q && out_stall_i)) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded");

endmodule
